// ----- design/tdl_pkg.sv -----
// Shared types and constants of the tile lookup-or-insert unit.
package tdl_pkg;

    // Number of slot match bits folded together by one group reducer.
    localparam int GROUP_SIZE = 32;

    // Width of the reported slot index.
    localparam int INDEX_W = 8;

    // One input item: the two bit planes of an 8x8 tile.
    typedef struct packed {
        logic [63:0] plane_low;
        logic [63:0] plane_high;
    } tile_t;

    // One result item.
    typedef struct packed {
        logic [INDEX_W-1:0] tile_index;
        logic               was_inserted;
        logic               store_full;
    } result_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_DECIDE
    } state_t;

endpackage

// ----- design/tdl_cell.sv -----
// One storage cell of the tile chain: holds a tile, compares it and shifts it on.
module tdl_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift_en,
    input  tdl_pkg::tile_t entry_in,
    input  logic           probe_en,
    input  tdl_pkg::tile_t probe,
    input  logic           occupied,
    output tdl_pkg::tile_t entry_out,
    output logic           match
);

    tdl_pkg::tile_t entry_reg;
    logic           match_reg;

    // On an insertion every cell takes the tile of its neighbour.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= entry_in;
        end
    end

    // The match flag is captured when a new item is accepted.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (probe_en)
        begin
            match_reg <= occupied && (entry_reg == probe);
        end
    end

    assign entry_out = entry_reg;
    assign match     = match_reg;

endmodule

// ----- design/tdl_group_or.sv -----
// Registered reduction of one group of cell match flags into a hit and a position.
module tdl_group_or
#(
    parameter int POS_W = 8,
    parameter int BASE  = 0
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [tdl_pkg::GROUP_SIZE-1:0]   match_flags,
    output logic                             hit,
    output logic [POS_W-1:0]                 pos
);

    logic             hit_reg;
    logic             hit_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    // A tile is only ever stored once, so at most one flag is set and the
    // positions can simply be ORed together.
    always_comb
    begin
        hit_next = 1'b0;
        pos_next = '0;
        for (int j = 0; j < tdl_pkg::GROUP_SIZE; j++)
        begin
            hit_next = hit_next | match_flags[j];
            pos_next = pos_next | (match_flags[j] ? POS_W'(BASE + j) : '0);
        end
    end

    // Group result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (load)
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_reg <= pos_next;
        end
    end

    assign hit = hit_reg;
    assign pos = pos_reg;

endmodule

// ----- design/tile_dedup_lookup_insert_unit.sv -----
// Top level of the tile lookup-or-insert unit: cell chain, reducers and sequencer.
//
// Each 8x8 two-plane tile is compared against every stored tile in parallel;
// the hit index or, on a miss, the freshly appended slot comes back as one
// result item, with a full flag when the store is full. The match flags are
// registered in all cells at acceptance, then the group reduction of them is
// registered, then the final reduction and decision load the result. A new
// tile is taken only after the decision on the last one; a result that is
// not taken holds the unit before its next decision.
// Tiles live in a chain of cells: a new tile enters the first cell and every
// stored tile moves on by one, so the cell at position p holds slot
// count-1-p. The store is empty after reset and needs no clearing pass; a
// tileset is preloaded by feeding its tiles in order.
module tile_dedup_lookup_insert_unit
#(
    parameter int TILE_SLOTS = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tile_valid,
    output logic             tile_ready,
    input  tdl_pkg::tile_t   tile,
    output logic             result_valid,
    input  logic             result_ready,
    output tdl_pkg::result_t result
);

    localparam int POS_W    = (TILE_SLOTS > 1) ? $clog2(TILE_SLOTS) : 1;
    localparam int CNT_W    = $clog2(TILE_SLOTS + 1);
    localparam int GROUPS   = (TILE_SLOTS + tdl_pkg::GROUP_SIZE - 1) / tdl_pkg::GROUP_SIZE;
    localparam int PADDED   = GROUPS * tdl_pkg::GROUP_SIZE;

    tdl_pkg::state_t  state_reg;
    tdl_pkg::state_t  state_next;

    tdl_pkg::tile_t   tile_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    tdl_pkg::result_t result_reg;
    tdl_pkg::result_t result_next;
    logic             result_valid_reg;
    logic             result_valid_next;

    logic             accept;
    logic             group_load;
    logic             decide_fire;
    logic             shift_en;

    tdl_pkg::tile_t   entry_out [TILE_SLOTS];
    logic [PADDED-1:0] match_vec;
    logic [GROUPS-1:0] group_hit;
    logic [POS_W-1:0]  group_pos [GROUPS];

    logic             any_hit;
    logic [POS_W-1:0] hit_pos;
    logic             is_full;
    logic [CNT_W-1:0] hit_slot;

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tdl_pkg::ST_IDLE:
            begin
                if (tile_valid)
                begin
                    state_next = tdl_pkg::ST_GROUP;
                end
            end
            tdl_pkg::ST_GROUP:
            begin
                state_next = tdl_pkg::ST_DECIDE;
            end
            tdl_pkg::ST_DECIDE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = tdl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdl_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        tile_ready  = 1'b0;
        group_load  = 1'b0;
        decide_fire = 1'b0;
        unique case (state_reg)
            tdl_pkg::ST_IDLE:
            begin
                tile_ready = 1'b1;
            end
            tdl_pkg::ST_GROUP:
            begin
                group_load = 1'b1;
            end
            tdl_pkg::ST_DECIDE:
            begin
                decide_fire = !result_valid_reg || result_ready;
            end
            default:
            begin
                tile_ready = 1'b0;
            end
        endcase
    end

    assign accept = tile_valid && tile_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The accepted tile is kept for insertion at the head of the chain.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tile_reg <= tile;
        end
    end

    // Chain of storage cells; cell 0 takes the newest tile.
    for (genvar p = 0; p < TILE_SLOTS; p++)
    begin : g_cell
        tdl_pkg::tile_t cell_in;
        if (p == 0)
        begin : g_head
            assign cell_in = tile_reg;
        end
        else
        begin : g_body
            assign cell_in = entry_out[p-1];
        end

        tdl_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (shift_en),
            .entry_in  (cell_in),
            .probe_en  (accept),
            .probe     (tile),
            .occupied  (count_reg > CNT_W'(p)),
            .entry_out (entry_out[p]),
            .match     (match_vec[p])
        );
    end

    // Positions beyond the last cell never match.
    for (genvar p = TILE_SLOTS; p < PADDED; p++)
    begin : g_pad
        assign match_vec[p] = 1'b0;
    end

    // First reduction level: one reducer per group of cells.
    for (genvar g = 0; g < GROUPS; g++)
    begin : g_group
        tdl_group_or
        #(
            .POS_W (POS_W),
            .BASE  (g * tdl_pkg::GROUP_SIZE)
        )
        u_group
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .load        (group_load),
            .match_flags (match_vec[g*tdl_pkg::GROUP_SIZE +: tdl_pkg::GROUP_SIZE]),
            .hit         (group_hit[g]),
            .pos         (group_pos[g])
        );
    end

    // Final reduction across the groups.
    always_comb
    begin
        any_hit = 1'b0;
        hit_pos = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            any_hit = any_hit | group_hit[g];
            hit_pos = hit_pos | (group_hit[g] ? group_pos[g] : '0);
        end
    end

    // The cell at position p holds slot count-1-p.
    assign hit_slot = count_reg - CNT_W'(1) - CNT_W'(hit_pos);
    assign is_full  = (count_reg == CNT_W'(TILE_SLOTS));
    assign shift_en = decide_fire && !any_hit && !is_full;

    // Decision: hit, insertion or full store.
    always_comb
    begin
        result_next = result_reg;
        count_next  = count_reg;
        if (decide_fire)
        begin
            priority if (any_hit)
            begin
                result_next.tile_index   = tdl_pkg::INDEX_W'(hit_slot);
                result_next.was_inserted = 1'b0;
                result_next.store_full   = 1'b0;
            end
            else if (!is_full)
            begin
                result_next.tile_index   = tdl_pkg::INDEX_W'(count_reg);
                result_next.was_inserted = 1'b1;
                result_next.store_full   = 1'b0;
                count_next               = count_reg + CNT_W'(1);
            end
            else
            begin
                result_next.tile_index   = tdl_pkg::INDEX_W'(TILE_SLOTS - 1);
                result_next.was_inserted = 1'b0;
                result_next.store_full   = 1'b1;
            end
        end
    end

    // Output register handshake.
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (decide_fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
